### design/midpoint_circle_framebuffer_defines.svh
// Assertion macros used by the frame buffer drawing engine.
`ifndef MIDPOINT_CIRCLE_FRAMEBUFFER_DEFINES_SVH
`define MIDPOINT_CIRCLE_FRAMEBUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mcf_pkg.sv
// Shared types and constants for the midpoint circle frame buffer.
package mcf_pkg;

  localparam int COLUMNS_DEFAULT = 128;
  localparam int PAGES_DEFAULT   = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] CMD_PLOT   = 2'd0;
  localparam logic [1:0] CMD_CIRCLE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // Classified command as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic       oor;     // point or read address off the display
    logic [7:0] x;
    logic [7:0] y;
    logic [5:0] radius;
    logic       color;
    logic [2:0] page;
    logic [7:0] column;
  } op_t;

endpackage

### design/mcf_front.sv
// Front end: accepts command beats and classifies them into queue entries.
module mcf_front #(
  parameter int COLUMNS = mcf_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mcf_pkg::PAGES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         hold,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   cmd,
  input  logic [7:0]   pos_x,
  input  logic [7:0]   pos_y,
  input  logic [5:0]   radius,
  input  logic         color,
  input  logic [2:0]   page_sel,
  input  logic [7:0]   column_sel,
  output logic         f_valid,
  output mcf_pkg::op_t f_data,
  input  logic         f_ready
);

  mcf_pkg::op_t op_in;
  logic         plot_oor;
  logic         read_oor;

  assign in_ready = !hold && (!f_valid || f_ready);

  assign plot_oor = (32'(pos_x) >= COLUMNS) || (32'(pos_y[7:3]) >= PAGES);
  assign read_oor = (32'(column_sel) >= COLUMNS) || (32'(page_sel) >= PAGES);

  always_comb begin
    op_in.kind   = cmd;
    op_in.x      = pos_x;
    op_in.y      = pos_y;
    op_in.radius = radius;
    op_in.color  = color;
    op_in.page   = page_sel;
    op_in.column = column_sel;
    unique case (cmd)
      mcf_pkg::CMD_PLOT: op_in.oor = plot_oor;
      mcf_pkg::CMD_READ: op_in.oor = read_oor;
      default:           op_in.oor = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_data <= op_in;
    end
  end

endmodule

### design/mcf_queue.sv
// Short command queue between the front end and the drawing engine.
module mcf_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  mcf_pkg::op_t push_data,
  output logic         pop_valid,
  input  logic         pop,
  output mcf_pkg::op_t pop_data
);

  localparam int DEPTH = mcf_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  mcf_pkg::op_t     entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### design/mcf_back.sv
// Drawing engine: circle walker, frame store read-modify-write and result register.
`include "midpoint_circle_framebuffer_defines.svh"

module mcf_back #(
  parameter int COLUMNS = mcf_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mcf_pkg::PAGES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  mcf_pkg::op_t q_data,
  output logic         q_pop,
  output logic         clearing,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         status,
  output logic [7:0]   read_data
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CIRCLE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [AW-1:0]     clr_addr;

  // circle walker
  logic [7:0]        cx;
  logic [7:0]        cy;
  logic              color_r;
  logic [6:0]        walk_x;
  logic [6:0]        walk_y;
  logic signed [8:0] decision;
  logic [2:0]        oct;
  logic [7:0]        u8;
  logic [7:0]        v8;
  logic [7:0]        cir_x;
  logic [7:0]        cir_y;
  logic              cir_oor;
  logic [6:0]        py_next;
  logic [6:0]        px_next;
  logic signed [10:0] d_ext;
  logic signed [10:0] d_sum;
  logic              d_pos;
  logic              walk_cont;
  logic              walk_load;
  logic              walk_step;

  // issue stage
  logic              iss_valid;
  logic              iss_write;
  logic              iss_color;
  logic              sel_read;
  logic [7:0]        pt_x;
  logic [7:0]        pt_y;
  logic [2:0]        idx_page;
  logic [7:0]        idx_col;
  logic [AW-1:0]     iss_addr;

  // write stage
  logic              s2_valid;
  logic              s2_write;
  logic [AW-1:0]     s2_addr;
  logic [7:0]        s2_mask;
  logic              s2_color;
  logic [7:0]        rd_q;
  logic [7:0]        merged;
  logic [7:0]        new_byte;
  logic              wl_valid;
  logic [AW-1:0]     wl_addr;
  logic [7:0]        wl_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        frame_mem [DEPTH];

  // result register
  logic              out_free;
  logic              out_load;
  logic              out_status_in;
  logic [7:0]        out_data_in;

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || out_ready;

  // symmetric point selected by the octant counter
  assign u8 = {1'b0, walk_x};
  assign v8 = {1'b0, walk_y};

  always_comb begin
    case (oct)
      3'd0:    begin cir_x = cx + u8; cir_y = cy + v8; end
      3'd1:    begin cir_x = cx + v8; cir_y = cy + u8; end
      3'd2:    begin cir_x = cx - v8; cir_y = cy + u8; end
      3'd3:    begin cir_x = cx - u8; cir_y = cy + v8; end
      3'd4:    begin cir_x = cx - u8; cir_y = cy - v8; end
      3'd5:    begin cir_x = cx - v8; cir_y = cy - u8; end
      3'd6:    begin cir_x = cx + v8; cir_y = cy - u8; end
      default: begin cir_x = cx + u8; cir_y = cy - v8; end
    endcase
  end

  assign cir_oor = (32'(cir_x) >= COLUMNS) || (32'(cir_y[7:3]) >= PAGES);

  // midpoint step: y always advances, x steps in when the error term is positive
  assign py_next = walk_y + 7'd1;
  assign d_pos   = (decision > 9'sd0);
  assign px_next = d_pos ? walk_x - 7'd1 : walk_x;
  assign d_ext   = 11'(decision);
  always_comb begin
    if (d_pos) begin
      d_sum = d_ext + $signed({3'b000, py_next, 1'b0}) - $signed({3'b000, walk_x, 1'b0})
              + 11'sd3;
    end else begin
      d_sum = d_ext + $signed({3'b000, py_next, 1'b0}) + 11'sd1;
    end
  end
  assign walk_cont = d_pos ? (walk_x > py_next) : (walk_x >= py_next);

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    iss_valid     = 1'b0;
    iss_write     = 1'b0;
    iss_color     = color_r;
    sel_read      = 1'b0;
    pt_x          = q_data.x;
    pt_y          = q_data.y;
    out_load      = 1'b0;
    out_status_in = 1'b0;
    out_data_in   = 8'd0;
    walk_load     = 1'b0;
    walk_step     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            mcf_pkg::CMD_PLOT: begin
              iss_valid     = !q_data.oor;
              iss_write     = 1'b1;
              iss_color     = q_data.color;
              out_load      = 1'b1;
              out_status_in = q_data.oor;
            end
            mcf_pkg::CMD_CIRCLE: begin
              walk_load  = 1'b1;
              state_next = ST_CIRCLE;
            end
            mcf_pkg::CMD_READ: begin
              if (q_data.oor) begin
                out_load      = 1'b1;
                out_status_in = 1'b1;
              end else begin
                iss_valid  = 1'b1;
                sel_read   = 1'b1;
                state_next = ST_READ;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_CIRCLE: begin
        pt_x      = cir_x;
        pt_y      = cir_y;
        iss_valid = !cir_oor;
        iss_write = 1'b1;
        if (oct == 3'd7) begin
          walk_step = 1'b1;
          if (!walk_cont) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        out_load    = 1'b1;
        out_data_in = merged;
        state_next  = ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // byte address: page * COLUMNS + column
  assign idx_page = sel_read ? q_data.page : pt_y[5:3];
  assign idx_col  = sel_read ? q_data.column : pt_x;
  assign iss_addr = AW'(32'(idx_page) * COLUMNS + 32'(idx_col));

  // forward the previous cycle's write, the memory returns old data on a collision
  assign merged    = (wl_valid && (wl_addr == s2_addr)) ? wl_data : rd_q;
  assign new_byte  = s2_color ? (merged | s2_mask) : (merged & ~s2_mask);
  assign mem_we    = clearing || (s2_valid && s2_write);
  assign mem_waddr = clearing ? clr_addr : s2_addr;
  assign mem_wdata = clearing ? 8'd0 : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= frame_mem[iss_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      s2_valid <= 1'b0;
      wl_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s2_valid <= iss_valid;
      wl_valid <= mem_we;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_write <= iss_write;
    s2_addr  <= iss_addr;
    s2_mask  <= 8'd1 << pt_y[2:0];
    s2_color <= iss_color;
    wl_addr  <= mem_waddr;
    wl_data  <= mem_wdata;
    if (out_load) begin
      status    <= out_status_in;
      read_data <= out_data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= '0;
      cy       <= '0;
      color_r  <= 1'b0;
      walk_x   <= '0;
      walk_y   <= '0;
      decision <= '0;
      oct      <= '0;
    end else if (walk_load) begin
      cx       <= q_data.x;
      cy       <= q_data.y;
      color_r  <= q_data.color;
      walk_x   <= {1'b0, q_data.radius};
      walk_y   <= '0;
      decision <= 9'(10'sd1 - $signed({4'b0000, q_data.radius}));
      oct      <= '0;
    end else if (state == ST_CIRCLE) begin
      oct <= oct + 3'd1;
      if (walk_step) begin
        walk_x   <= px_next;
        walk_y   <= py_next;
        decision <= 9'(d_sum);
      end
    end
  end

  `MCF_ASSERT_NOW(a_no_pop_in_clear, clearing, !q_pop, "queue popped during clear pass")
  `MCF_ASSERT_NEXT(a_read_returns, state == ST_READ, out_valid,
                   "read result not presented after read cycle")
  `MCF_ASSERT_NEXT(a_octant_steps, (state == ST_CIRCLE) && (oct != 3'd7),
                   (state == ST_CIRCLE) && (oct == 3'($past(oct) + 3'd1)),
                   "circle octant sequence broken")

endmodule

### design/midpoint_circle_framebuffer.sv
// Top level of the midpoint circle frame buffer: front end, queue and drawing engine.
//
// Page-organized monochrome frame store (PAGES pages of COLUMNS bytes, bit 0 is the top
// row of a page) with plot, midpoint circle and byte readback commands. After reset the
// store is swept to zero, one byte a cycle; in_ready stays low during the sweep.
// Commands pass through a two-entry queue, so new beats are taken while a result waits
// on the output. A read takes a registered memory read before its result is loaded, and
// a circle visits all eight octant points per walk step. While drawing a circle the
// engine does one read-modify-write pixel a cycle through the frame store, which sets
// the circle rate.
module midpoint_circle_framebuffer #(
  parameter int COLUMNS = mcf_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mcf_pkg::PAGES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [5:0] radius,
  input  logic       color,
  input  logic [2:0] page_sel,
  input  logic [7:0] column_sel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       status,
  output logic [7:0] read_data
);

  logic         f_valid;
  logic         f_ready;
  mcf_pkg::op_t f_data;
  logic         q_valid;
  logic         q_pop;
  mcf_pkg::op_t q_data;
  logic         clearing;

  mcf_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .radius    (radius),
    .color     (color),
    .page_sel  (page_sel),
    .column_sel(column_sel),
    .f_valid   (f_valid),
    .f_data    (f_data),
    .f_ready   (f_ready)
  );

  mcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  mcf_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .read_data(read_data)
  );

endmodule
